// ===== design/spa_pkg.sv =====
// Package for the sparse polynomial unit: widths, codes, queue entry type and
// Q16.16 saturating arithmetic helpers. No dependencies.
`default_nettype none
package spa_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int COEF_W        = 32;
	localparam int EXP_W         = 5;
	localparam int REXP_W        = 6;
	localparam int RES_DEPTH     = 64;
	localparam int RA_W          = 6;
	localparam int RN_W          = 7;
	localparam int TIDX_W        = 5;
	localparam int TCNT_W        = 6;
	localparam int QUEUE_DEPTH   = 4;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 72;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_MUL  = 2'd1;
	localparam logic [1:0] MODE_EVAL = 2'd2;
	localparam logic [1:0] MODE_RSV  = 2'd3;

	localparam logic CFG_OP_MODE = 1'b0;
	localparam logic CFG_X_POINT = 1'b1;

	localparam logic [COEF_W-1:0] Q_ONE = 32'h0001_0000;
	localparam logic [COEF_W-1:0] CMAX  = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] CMIN  = 32'h8000_0000;

	typedef struct packed {
		logic              store;
		logic              which;
		logic [TIDX_W-1:0] idx;
		logic [COEF_W-1:0] coef;
		logic [EXP_W-1:0]  expo;
		logic              run;
		logic [1:0]        mode;
		logic              err;
		logic [TCNT_W-1:0] a_n;
		logic [TCNT_W-1:0] b_n;
	} entry_t;

	typedef struct packed {
		logic              ovf;
		logic [COEF_W-1:0] val;
	} sat_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} back_st_t;

	// floor(p / 2^16), saturated to 32 bits
	function automatic sat_t mul_sat(input logic signed [63:0] p);
		logic signed [63:0] s;
		sat_t r;
		s = p >>> 16;
		r.ovf = !((&s[63:31]) || !(|s[63:31]));
		r.val = r.ovf ? (s[63] ? CMIN : CMAX) : s[31:0];
		return r;
	endfunction

	function automatic sat_t add_sat(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b);
		logic [COEF_W:0] s;
		sat_t r;
		s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
		r.ovf = s[COEF_W] ^ s[COEF_W-1];
		r.val = r.ovf ? (s[COEF_W] ? CMIN : CMAX) : s[COEF_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/sparse_polynomial_add_mul_eval_top.sv =====
// Sparse polynomial add / multiply / evaluate unit, top level.
// Terms load one per cycle into a 4-word queue while it is not full; a run starts on
// the closing term. Multiply runs term pairs through a shared 32x32 multiplier.
// Evaluate raises x by repeated multiply for each term of A. Results leave one word at a time.
// arst_n clears counts, state and output valid; term stores are not cleared.
`default_nettype none
module sparse_polynomial_add_mul_eval_top import spa_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [COEF_W-1:0]     cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // term_coef_in, term_exp_in, zero pad
	input  wire logic                  s_tuser,   // which_poly
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // result_coef, result_exp, poly_value, zero pad
	output logic                       m_tuser,   // error_flag
	output logic                       m_tlast
);
	logic [1:0]        op_mode_q;
	logic [COEF_W-1:0] x_point_q;
	logic              push, q_full, q_empty;
	entry_t            f_entry, q_entry;
	back_st_t          bst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= MODE_ADD;
			x_point_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OP_MODE: op_mode_q <= cfg_data[1:0];
				CFG_X_POINT: x_point_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	spa_front #(.MAX_TERMS(MAX_TERMS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.op_mode(op_mode_q), .q_full(q_full), .push(push), .entry(f_entry)
	);

	spa_queue #(.W($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(f_entry), .pop(bst.pop), .rdata(q_entry),
		.full(q_full), .empty(q_empty)
	);

	spa_back #(.MAX_TERMS(MAX_TERMS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_entry(q_entry), .st(bst), .x_point(x_point_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bst.pop |-> !q_empty)
		else $error("queue popped while empty");

	a_run_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(bst.pop && q_entry.run) |=> !bst.idle)
		else $error("run did not start");

	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!bst.idle |-> !bst.pop)
		else $error("queue popped during a run");
endmodule
`default_nettype wire

// ===== design/spa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/spa_queue.sv =====
// Short FIFO between the term front end and the compute back end.
// No package dependency.
`default_nettype none
module spa_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic      [W-1:0] rdata,
	output logic              full,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  buf_q [DEPTH];
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[tail_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/spa_front.sv =====
// Front end: accepts term words, tracks list fill and drops, marks run start.
// Depends on spa_pkg.
`default_nettype none
module spa_front import spa_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic                 s_tuser,
	input  wire logic                 s_tlast,
	input  wire logic [1:0]           op_mode,
	input  wire logic                 q_full,
	output logic                      push,
	output entry_t                    entry
);
	localparam int CW = $clog2(MAX_TERMS + 1);

	logic [CW-1:0] a_cnt_q, b_cnt_q;
	logic          sticky_q;
	logic [1:0]    mode;
	logic          full, trig, st_a, st_b;
	logic [CW-1:0] a_next, b_next;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		mode   = (op_mode == MODE_RSV) ? MODE_ADD : op_mode;
		full   = s_tuser ? (b_cnt_q == CW'(MAX_TERMS)) : (a_cnt_q == CW'(MAX_TERMS));
		trig   = s_tlast && ((mode == MODE_EVAL) ? !s_tuser : s_tuser);
		st_a   = !full && !s_tuser;
		st_b   = !full && s_tuser;
		a_next = a_cnt_q + CW'(st_a);
		b_next = b_cnt_q + CW'(st_b);

		entry.store = !full;
		entry.which = s_tuser;
		entry.idx   = TIDX_W'(s_tuser ? b_cnt_q : a_cnt_q);
		entry.coef  = s_tdata[COEF_W-1:0];
		entry.expo  = s_tdata[COEF_W+EXP_W-1:COEF_W];
		entry.run   = trig;
		entry.mode  = mode;
		entry.err   = sticky_q || full;
		entry.a_n   = TCNT_W'(a_next);
		entry.b_n   = TCNT_W'(b_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q  <= '0;
			b_cnt_q  <= '0;
			sticky_q <= 1'b0;
		end else if (push) begin
			if (trig) begin
				a_cnt_q  <= '0;
				b_cnt_q  <= '0;
				sticky_q <= 1'b0;
			end else begin
				a_cnt_q  <= a_next;
				b_cnt_q  <= b_next;
				sticky_q <= sticky_q || full;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/spa_back.sv =====
// Back end: term stores, add/multiply/evaluate sequencer, result buffer, output register.
// Depends on spa_pkg and spa_ram.
`default_nettype none
module spa_back import spa_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  entry_t                     q_entry,
	output back_st_t                   st,
	input  wire logic [COEF_W-1:0]     x_point,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int IW = $clog2(MAX_TERMS);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_EV_LD  = 11'b000_0000_0010,
		S_EV_PW  = 11'b000_0000_0100,
		S_EV_PWS = 11'b000_0000_1000,
		S_EV_ACC = 11'b000_0001_0000,
		S_ADD    = 11'b000_0010_0000,
		S_MU_MUL = 11'b000_0100_0000,
		S_MU_LK  = 11'b000_1000_0000,
		S_MU_UPD = 11'b001_0000_0000,
		S_EM_RD  = 11'b010_0000_0000,
		S_EM_OUT = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [COEF_W-1:0] a_coef_q [MAX_TERMS];
	logic [EXP_W-1:0]  a_exp_q  [MAX_TERMS];
	logic [COEF_W-1:0] b_coef_q [MAX_TERMS];
	logic [EXP_W-1:0]  b_exp_q  [MAX_TERMS];

	logic [1:0]         mode_q;
	logic [CW-1:0]      a_n_q, b_n_q, i_q, j_q;
	logic [RN_W-1:0]    n_q, k_q;
	logic               err_q;
	logic [COEF_W-1:0]  pw_q, tot_q, ecoef_q, c_q;
	logic [EXP_W-1:0]   ecnt_q, pj_q;
	logic signed [63:0] mul_q;
	logic [REXP_W-1:0]  me_q;
	logic [RES_DEPTH-1:0] vld_q;

	logic [COEF_W-1:0]  o_coef_q, o_val_q;
	logic [REXP_W-1:0]  o_exp_q;
	logic               o_vld_q, o_last_q, o_err_q;

	logic [COEF_W-1:0]  a_c, b_c;
	logic [EXP_W-1:0]   a_e, b_e;
	logic signed [COEF_W-1:0] op_a, op_b;
	sat_t               ms, as, ms2;
	logic               a_ok, b_ok, ld_out, is_last;
	logic [RN_W-1:0]    n_out;

	logic               r_we, s_we;
	logic [RA_W-1:0]    r_waddr, r_raddr, s_raddr;
	logic [REXP_W+COEF_W-1:0] r_wdata, r_rdata;
	logic [RA_W-1:0]    s_rdata;

	spa_ram #(.WIDTH(REXP_W + COEF_W), .DEPTH(RES_DEPTH)) u_res (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	spa_ram #(.WIDTH(RA_W), .DEPTH(RES_DEPTH)) u_slot (
		.clk(clk), .we(s_we), .waddr(me_q), .wdata(n_q[RA_W-1:0]),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	assign st.idle = (state_q == S_IDLE);
	assign st.pop  = st.idle && !q_empty;

	always_comb begin
		a_c  = a_coef_q[i_q[IW-1:0]];
		a_e  = a_exp_q[i_q[IW-1:0]];
		b_c  = b_coef_q[j_q[IW-1:0]];
		b_e  = b_exp_q[j_q[IW-1:0]];
		a_ok = (i_q < a_n_q);
		b_ok = (j_q < b_n_q);

		op_a = a_c;
		op_b = b_c;
		if (state_q == S_EV_PW) begin
			op_a = (pj_q < ecnt_q) ? x_point : ecoef_q;
			op_b = pw_q;
		end

		ms  = mul_sat(mul_q);
		as  = add_sat(tot_q, ms.val);
		ms2 = add_sat(r_rdata[COEF_W-1:0], c_q);

		s_raddr = (state_q == S_MU_MUL) ? REXP_W'({1'b0, a_e} + {1'b0, b_e}) : me_q;
		r_raddr = (state_q == S_MU_LK) ? s_rdata : k_q[RA_W-1:0];

		r_we    = 1'b0;
		r_waddr = n_q[RA_W-1:0];
		r_wdata = '0;
		s_we    = 1'b0;
		if (state_q == S_ADD && (a_ok || b_ok)) begin
			r_we = 1'b1;
			if (!b_ok || (a_ok && a_e > b_e)) begin
				r_wdata = {1'b0, a_e, a_c};
			end else if (!a_ok || a_e < b_e) begin
				r_wdata = {1'b0, b_e, b_c};
			end else begin
				r_wdata = {1'b0, a_e, add_sat(a_c, b_c).val};
			end
		end else if (state_q == S_MU_LK && !vld_q[me_q]) begin
			r_we    = 1'b1;
			s_we    = 1'b1;
			r_wdata = {me_q, ms.val};
		end else if (state_q == S_MU_UPD) begin
			r_we    = 1'b1;
			r_waddr = s_rdata;
			r_wdata = {me_q, ms2.val};
		end

		n_out   = (n_q == '0) ? RN_W'(1) : n_q;
		is_last = (k_q + 1'b1 == n_out);
		ld_out  = (state_q == S_EM_OUT) && (!o_vld_q || m_tready);
	end

	always_ff @(posedge clk) begin
		if (st.pop && q_entry.store) begin
			if (q_entry.which) begin
				b_coef_q[q_entry.idx[IW-1:0]] <= q_entry.coef;
				b_exp_q[q_entry.idx[IW-1:0]]  <= q_entry.expo;
			end else begin
				a_coef_q[q_entry.idx[IW-1:0]] <= q_entry.coef;
				a_exp_q[q_entry.idx[IW-1:0]]  <= q_entry.expo;
			end
		end
		if (state_q == S_EV_PW || state_q == S_MU_MUL) begin
			mul_q <= op_a * op_b;
		end
		if (state_q == S_MU_MUL) begin
			me_q <= s_raddr;
		end
		if (state_q == S_MU_LK) begin
			c_q <= ms.val;
		end
		if (ld_out) begin
			o_coef_q <= (mode_q == MODE_EVAL || n_q == '0) ? '0 : r_rdata[COEF_W-1:0];
			o_exp_q  <= (mode_q == MODE_EVAL || n_q == '0) ? '0
			            : r_rdata[REXP_W+COEF_W-1:COEF_W];
			o_val_q  <= (mode_q == MODE_EVAL) ? tot_q : '0;
			o_last_q <= is_last;
			o_err_q  <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_ADD;
			a_n_q   <= '0;
			b_n_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
			pw_q    <= '0;
			tot_q   <= '0;
			ecoef_q <= '0;
			ecnt_q  <= '0;
			pj_q    <= '0;
			vld_q   <= '0;
			o_vld_q <= 1'b0;
		end else begin
			if (ld_out) begin
				o_vld_q <= 1'b1;
			end else if (m_tready) begin
				o_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (st.pop && q_entry.run) begin
						mode_q <= q_entry.mode;
						a_n_q  <= q_entry.a_n[CW-1:0];
						b_n_q  <= q_entry.b_n[CW-1:0];
						err_q  <= q_entry.err;
						i_q    <= '0;
						j_q    <= '0;
						n_q    <= '0;
						k_q    <= '0;
						tot_q  <= '0;
						vld_q  <= '0;
						unique case (q_entry.mode)
							MODE_EVAL: state_q <= S_EV_LD;
							MODE_MUL:  state_q <= S_MU_MUL;
							default:   state_q <= S_ADD;
						endcase
					end
				end
				S_EV_LD: begin
					if (!a_ok) begin
						n_q     <= RN_W'(1);
						state_q <= S_EM_RD;
					end else begin
						ecoef_q <= a_c;
						ecnt_q  <= a_e;
						pw_q    <= Q_ONE;
						pj_q    <= '0;
						state_q <= S_EV_PW;
					end
				end
				S_EV_PW: begin
					state_q <= (pj_q < ecnt_q) ? S_EV_PWS : S_EV_ACC;
				end
				S_EV_PWS: begin
					pw_q    <= ms.val;
					err_q   <= err_q || ms.ovf;
					pj_q    <= pj_q + 1'b1;
					state_q <= S_EV_PW;
				end
				S_EV_ACC: begin
					tot_q   <= as.val;
					err_q   <= err_q || ms.ovf || as.ovf;
					i_q     <= i_q + 1'b1;
					state_q <= S_EV_LD;
				end
				S_ADD: begin
					if (!a_ok && !b_ok) begin
						state_q <= S_EM_RD;
					end else begin
						n_q <= n_q + 1'b1;
						if (!b_ok || (a_ok && a_e > b_e)) begin
							i_q <= i_q + 1'b1;
						end else if (!a_ok || a_e < b_e) begin
							j_q <= j_q + 1'b1;
						end else begin
							i_q   <= i_q + 1'b1;
							j_q   <= j_q + 1'b1;
							err_q <= err_q || add_sat(a_c, b_c).ovf;
						end
					end
				end
				S_MU_MUL: begin
					state_q <= (!a_ok || b_n_q == '0) ? S_EM_RD : S_MU_LK;
				end
				S_MU_LK: begin
					err_q <= err_q || ms.ovf;
					if (vld_q[me_q]) begin
						state_q <= S_MU_UPD;
					end else begin
						vld_q[me_q] <= 1'b1;
						n_q         <= n_q + 1'b1;
						state_q     <= S_MU_MUL;
						if (j_q + 1'b1 == b_n_q) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				S_MU_UPD: begin
					err_q   <= err_q || ms2.ovf;
					state_q <= S_MU_MUL;
					if (j_q + 1'b1 == b_n_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (ld_out) begin
						k_q     <= k_q + 1'b1;
						state_q <= is_last ? S_IDLE : S_EM_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = o_vld_q;
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_err_q;
	assign m_tdata  = {2'b00, o_val_q, o_exp_q, o_coef_q};
endmodule
`default_nettype wire

// ===== tb/sparse_polynomial_add_mul_eval_checker.sv =====
// Checker for the sparse polynomial unit: watches the config port and both streams,
// predicts result words from accepted terms and compares them. Depends on spa_pkg.
module sparse_polynomial_add_mul_eval_checker import spa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [COEF_W-1:0]     cfg_data,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  m_tuser,
	input  wire logic                  m_tlast,
	output int                         pending,
	output int                         fails
);

	typedef struct packed {
		logic [31:0] coef;
		logic [5:0]  expo;
		logic [31:0] value;
		logic        last;
		logic        err;
	} res_word_t;

	res_word_t want_q[$];

	logic [1:0]         mode_r;
	logic signed [31:0] x_r;
	logic signed [31:0] a_c[MAX_TERMS_DEF];
	logic [4:0]         a_e[MAX_TERMS_DEF];
	logic signed [31:0] b_c[MAX_TERMS_DEF];
	logic [4:0]         b_e[MAX_TERMS_DEF];
	logic signed [31:0] p_c[RES_DEPTH];
	logic [5:0]         p_e[RES_DEPTH];
	int                 a_n, b_n;
	bit                 sticky, run_err;

	function automatic logic signed [31:0] clamp(input longint v);
		if (v > 64'sd2147483647) begin
			run_err = 1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			run_err = 1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp(p >>> 16);
	endfunction

	function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp(longint'(a) + longint'(b));
	endfunction

	task automatic push(input logic [31:0] c, input logic [5:0] e, input logic [31:0] v);
		res_word_t w;
		w.coef = c;
		w.expo = e;
		w.value = v;
		w.last = 0;
		w.err = 0;
		want_q.push_back(w);
	endtask

	task automatic predict_term(input logic which, input logic signed [31:0] coef,
			input logic [4:0] ex, input logic last);
		logic [1:0]         md;
		logic signed [31:0] tot, pw, c;
		logic [5:0]         e;
		int                 i, j, k, pn, first;
		md = (mode_r == MODE_RSV) ? MODE_ADD : mode_r;
		if (!which) begin
			if (a_n < MAX_TERMS_DEF) begin
				a_c[a_n] = coef;
				a_e[a_n] = ex;
				a_n++;
			end else sticky = 1;
		end else begin
			if (b_n < MAX_TERMS_DEF) begin
				b_c[b_n] = coef;
				b_e[b_n] = ex;
				b_n++;
			end else sticky = 1;
		end
		if (!last || ((md == MODE_EVAL) != (which == 0)))
			return;
		run_err = sticky;
		first = want_q.size();
		if (md == MODE_EVAL) begin
			tot = 0;
			for (i = 0; i < a_n; i++) begin
				pw = Q_ONE;
				for (j = 0; j < a_e[i]; j++)
					pw = q_mul(pw, x_r);
				tot = q_add(tot, q_mul(a_c[i], pw));
			end
			push(0, 0, tot);
		end else if (md == MODE_ADD) begin
			i = 0;
			j = 0;
			while (i < a_n || j < b_n) begin
				if (j >= b_n || (i < a_n && a_e[i] > b_e[j])) begin
					push(a_c[i], a_e[i], 0);
					i++;
				end else if (i >= a_n || a_e[i] < b_e[j]) begin
					push(b_c[j], b_e[j], 0);
					j++;
				end else begin
					push(q_add(a_c[i], b_c[j]), a_e[i], 0);
					i++;
					j++;
				end
			end
		end else begin
			pn = 0;
			for (i = 0; i < a_n; i++)
				for (j = 0; j < b_n; j++) begin
					c = q_mul(a_c[i], b_c[j]);
					e = a_e[i] + b_e[j];
					for (k = 0; k < pn; k++)
						if (p_e[k] == e)
							break;
					if (k < pn)
						p_c[k] = q_add(p_c[k], c);
					else if (pn < RES_DEPTH) begin
						p_c[pn] = c;
						p_e[pn] = e;
						pn++;
					end else run_err = 1;
				end
			for (k = 0; k < pn; k++)
				push(p_c[k], p_e[k], 0);
		end
		if (want_q.size() == first)
			push(0, 0, 0);
		want_q[want_q.size()-1].last = 1;
		for (k = first; k < want_q.size(); k++)
			want_q[k].err = run_err;
		a_n = 0;
		b_n = 0;
		sticky = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_word_t w, g;
		if (!arst_n) begin
			mode_r = MODE_ADD;
			x_r = 0;
			a_n = 0;
			b_n = 0;
			sticky = 0;
			fails = 0;
			want_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_OP_MODE)
					mode_r = cfg_data[1:0];
				else
					x_r = cfg_data;
			end
			if (s_tvalid && s_tready)
				predict_term(s_tuser, s_tdata[31:0], s_tdata[36:32], s_tlast);
			if (m_tvalid && m_tready) begin
				g.coef = m_tdata[31:0];
				g.expo = m_tdata[37:32];
				g.value = m_tdata[69:38];
				g.last = m_tlast;
				g.err = m_tuser;
				if (want_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result word coef %h exp %0d value %h",
							g.coef, g.expo, g.value);
				end else begin
					w = want_q.pop_front();
					if (w !== g) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp coef %h exp %0d val %h last %b err %b, got coef %h exp %0d val %h last %b err %b",
								w.coef, w.expo, w.value, w.last, w.err,
								g.coef, g.expo, g.value, g.last, g.err);
					end
				end
			end
		end
		pending = want_q.size();
	end

endmodule

// ===== tb/sparse_polynomial_add_mul_eval_top_tb.sv =====
// Testbench top for the sparse polynomial unit: clock, reset, config writes, term runs
// and result back-pressure. Depends on spa_pkg and the checker module.
module sparse_polynomial_add_mul_eval_top_tb;
	import spa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic                  cfg_index = 0;
	logic [COEF_W-1:0]     cfg_data = 0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = 0;
	logic                  s_tuser = 0;
	logic                  s_tlast = 0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	int                    pending, fails;
	int                    idle_s = 0, idle_r = 0;
	int                    n_terms = 0, cycles = 0;

	sparse_polynomial_add_mul_eval_top uut (.*);
	sparse_polynomial_add_mul_eval_checker chk (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sparse_polynomial_add_mul_eval_top test failed");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= idle_r);

	task automatic put_term(input logic which, input logic [31:0] coef, input int ex,
			input logic last);
		bit ok;
		while ($urandom_range(99) < idle_s) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= which;
		s_tlast <= last;
		s_tdata <= {3'b0, ex[4:0], coef};
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		n_terms++;
	endtask

	task automatic write_cfg(input logic idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// drop valid and let the unit drain before touching config
	task automatic drain();
		s_tvalid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coef();
		case ($urandom_range(7))
			0: return CMAX;
			1: return CMIN;
			2: return 0;
			3, 4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic rnd_run();
		int na, nb, i, ex;
		logic [1:0] md;
		logic [31:0] x;
		int ea[$], eb[$];
		idle_s = 0;
		idle_r = 0;
		case ($urandom_range(3))
			1: idle_s = 81;
			2: idle_r = 81;
			3: begin
				idle_s = 35;
				idle_r = 35;
			end
			default: ;
		endcase
		md = 2'($urandom_range(3));
		case ($urandom_range(3))
			0: x = $urandom;
			1: x = $urandom_range(0, 32'h40000) - 32'h20000;
			2: x = ($urandom_range(1)) ? CMAX : CMIN;
			default: x = $urandom_range(0, 32'h1ffff);
		endcase
		write_cfg(CFG_OP_MODE, {30'b0, md});
		write_cfg(CFG_X_POINT, x);
		na = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 5);
		nb = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 5);
		if (md == MODE_EVAL) begin
			if (na == 0)
				na = 1;
			nb = $urandom_range(0, 2);
		end
		for (i = 0; i < na; i++)
			ea.push_back($urandom_range(31));
		for (i = 0; i < nb; i++)
			eb.push_back($urandom_range(31));
		if ($urandom_range(5) != 0) begin
			ea.rsort();
			eb.rsort();
		end
		if (md == MODE_EVAL) begin
			for (i = 0; i < nb; i++)
				put_term(1, rnd_coef(), eb[i], 1'($urandom_range(1)));
			for (i = 0; i < na; i++)
				put_term(0, rnd_coef(), ea[i], i == na - 1);
		end else begin
			for (i = 0; i < na; i++)
				put_term(0, rnd_coef(), ea[i], $urandom_range(7) == 0);
			for (i = 0; i < nb; i++)
				put_term(1, rnd_coef(), eb[i], i == nb - 1);
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// evaluate at 1.0, extremes of coefficient and exponent
		write_cfg(CFG_OP_MODE, {30'b0, MODE_EVAL});
		write_cfg(CFG_X_POINT, Q_ONE);
		put_term(0, CMAX, 31, 0);
		put_term(0, CMIN, 0, 1);
		drain();
		// saturated power with zero coefficient; x^0 at x = 0
		write_cfg(CFG_X_POINT, CMIN);
		put_term(0, 0, 3, 0);
		put_term(1, 5, 2, 1);
		put_term(0, Q_ONE, 0, 1);
		drain();
		write_cfg(CFG_X_POINT, 0);
		put_term(0, CMAX, 0, 1);
		drain();
		// mode three acts as add, saturating sum on equal exponents
		write_cfg(CFG_OP_MODE, {30'b0, MODE_RSV});
		put_term(0, CMAX, 3, 0);
		put_term(0, 5, 1, 1);
		put_term(1, CMAX, 3, 0);
		put_term(1, CMIN, 0, 1);
		drain();
		write_cfg(CFG_OP_MODE, {30'b0, MODE_ADD});
		put_term(0, 32'hffff_0000, 7, 0);
		put_term(1, Q_ONE, 7, 1);
		drain();
		// multiply, then multiply with empty A
		write_cfg(CFG_OP_MODE, {30'b0, MODE_MUL});
		put_term(0, CMIN, 31, 0);
		put_term(1, CMIN, 31, 0);
		put_term(1, Q_ONE, 0, 1);
		drain();
		put_term(1, 32'h0003_0000, 2, 1);
		drain();

		while (n_terms < 360)
			rnd_run();

		repeat (200) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("sparse_polynomial_add_mul_eval_top test passed");
		else
			$display("sparse_polynomial_add_mul_eval_top test failed");
		$finish;
	end

endmodule
